// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue.
// Holds the entry layout, the control word passed along the cell row and
// the operation and error codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int PRIO_W  = 7;
  localparam int CHAR_W  = 8;
  localparam int ERR_W   = 2;
  localparam int COUNT_W = 5;

  // Operation carried in the input word's tuser bit.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Error codes reported with each result.
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // One held entry.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [CHAR_W-1:0] ch;
  } entry_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic del;
  } ctl_t;

endpackage

// File: sv/sorted_priority_queue_core.sv
// Result: a result word appears in the cycle after its input word is accepted.
// Throughput: one word per cycle unless out_tready holds back the result word;
// the whole row of slot cells updates at once on an enqueue or dequeue.
// Reset: synchronous, active low; clears the occupancy count and the output
// valid flag. Slot contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: sorted priority queue of character entries.
// A row of slot cells keeps entries in nondecreasing priority, ties in arrival
// order; enqueue inserts in place, dequeue returns and removes the head.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] in_prio, [14:7] in_char, [15] zero
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [6:0] out_prio, [14:7] out_char,
                                  // [16:15] error_code, [21:17] entry_count,
                                  // [22] is_empty, [23] is_full
  output logic        out_tuser   // [0] out_valid
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          accept;
  logic          op;
  entry_t        new_ent;
  logic [CW-1:0] occ_r;
  logic [CW-1:0] occ_nxt;
  logic          full;
  logic          empty;
  ctl_t          ctl;
  logic [ERR_W-1:0] err;

  entry_t        ents   [DEPTH];
  logic          shifts [DEPTH];

  logic          out_tvalid_r;
  logic          res_valid_r;
  entry_t        res_ent_r;
  logic [ERR_W-1:0] res_err_r;
  logic [COUNT_W-1:0] res_count_r;
  logic          res_empty_r;
  logic          res_full_r;
  logic [CW+COUNT_W-1:0] occ_ext;

  // Input word decode and handshake.
  assign in_tready   = !out_tvalid_r || out_tready;
  assign accept      = in_tvalid && in_tready;
  assign op          = in_tuser;
  assign new_ent.prio = in_tdata[PRIO_W-1:0];
  assign new_ent.ch   = in_tdata[PRIO_W+CHAR_W-1:PRIO_W];

  assign full  = (occ_r == CW'(DEPTH));
  assign empty = (occ_r == '0);

  // Commands to the cell row, with overflow and underflow blocked.
  always_comb begin
    ctl.ins = 1'b0;
    ctl.del = 1'b0;
    err     = ERR_OK;
    occ_nxt = occ_r;
    if (accept) begin
      if (op == OP_ENQUEUE) begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          ctl.ins = 1'b1;
          occ_nxt = occ_r + 1'b1;
        end
      end else begin
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          ctl.del = 1'b1;
          occ_nxt = occ_r - 1'b1;
        end
      end
    end
  end

  // Row of slot cells, slot 0 is the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   in_use;
    logic   left_shift;
    entry_t left_ent;
    entry_t right_ent;

    assign in_use = (occ_r > CW'(i));

    if (i == 0) begin : g_head
      assign left_shift = 1'b0;
      assign left_ent   = new_ent;
    end else begin : g_body
      assign left_shift = shifts[i-1];
      assign left_ent   = ents[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = ents[i];
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .in_use     (in_use),
      .new_ent    (new_ent),
      .left_ent   (left_ent),
      .left_shift (left_shift),
      .right_ent  (right_ent),
      .shift_out  (shifts[i]),
      .ent_out    (ents[i])
    );
  end

  // Occupancy count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (accept) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign occ_ext = {{COUNT_W{1'b0}}, occ_nxt};

  // Result word register.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_valid_r <= ctl.del;
      res_ent_r   <= ctl.del ? ents[0] : '0;
      res_err_r   <= err;
      res_count_r <= occ_ext[COUNT_W-1:0];
      res_empty_r <= (occ_nxt == '0);
      res_full_r  <= (occ_nxt == CW'(DEPTH));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = res_valid_r;
  assign out_tdata  = {res_full_r, res_empty_r, res_count_r, res_err_r,
                       res_ent_r.ch, res_ent_r.prio};

endmodule

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue.
// On an insert the cell keeps its entry, takes the new one, or takes its
// left neighbour's entry when the insertion point lies to its left. On a
// removal it takes its right neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic           clk,
  input  spq_pkg::ctl_t  ctl,
  input  logic           in_use,
  input  spq_pkg::entry_t new_ent,
  input  spq_pkg::entry_t left_ent,
  input  logic           left_shift,
  input  spq_pkg::entry_t right_ent,
  output logic           shift_out,
  output spq_pkg::entry_t ent_out
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // An unused slot, or one less urgent than the new entry, moves back.
  assign shift_out = !in_use || (ent_r.prio > new_ent.prio);
  assign ent_out   = ent_r;

  // Select the slot's next entry.
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (left_shift) begin
        ent_nxt = left_ent;
      end else if (shift_out) begin
        ent_nxt = new_ent;
      end
    end else if (ctl.del) begin
      ent_nxt = right_ent;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// File: tb/sv/tb_sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_core: self-checking bench for the priority queue.
// A short table of directed words covers the empty and full error cases, the
// priority and character extremes and ties, then biased random traffic drives
// the queue between empty and full. Every result word is compared with an
// internal sorted-queue predictor or a typed row's fixed word, under random
// stalls on both sides, a long output hold-off and a drained pause.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int PHASE_WORDS = 450;
  localparam int DIR_N       = 23;
  localparam int HOLD_AT     = DIR_N + 2 * PHASE_WORDS + 100;
  localparam int HOLD_LEN    = 200;
  localparam int SHOW_MAX    = 10;

  // One result word, laid out as {out_tuser, out_tdata}.
  typedef struct packed {
    logic               valid;
    logic               full;
    logic               empty;
    logic [COUNT_W-1:0] count;
    logic [ERR_W-1:0]   err;
    logic [CHAR_W-1:0]  ch;
    logic [PRIO_W-1:0]  prio;
  } qresult_t;

  // One row of the directed table; fixed is used only where typed is set.
  typedef struct packed {
    logic              op;
    logic [PRIO_W-1:0] prio;
    logic [CHAR_W-1:0] ch;
    logic              typed;
    qresult_t          fixed;
  } row_t;

  localparam qresult_t NO_FIXED = '0;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  // Predicted queue contents, head in slot 0.
  logic [PRIO_W-1:0] slot_prio [DEPTH];
  logic [CHAR_W-1:0] slot_char [DEPTH];
  int                held = 0;

  qresult_t pending_results [$];
  int       fault_cnt     = 0;
  int       words_in      = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_left     = 0;
  bit       hold_done     = 1'b0;
  logic     word_typed    = 1'b0;
  qresult_t word_fixed    = '0;

  row_t dir_rows [DIR_N] = '{
    '{OP_DEQUEUE, 7'd127, 8'hFF, 1'b1,
      '{1'b0, 1'b0, 1'b1, 5'd0, ERR_EMPTY, 8'd0, 7'd0}},
    '{OP_ENQUEUE, 7'd100, 8'hFF, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd1,   8'h00, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd0,   8'hA5, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd127, 8'h5A, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd50,  8'h11, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd50,  8'h22, 1'b0, NO_FIXED},
    '{OP_DEQUEUE, 7'd0,   8'h00, 1'b0, NO_FIXED},
    '{OP_DEQUEUE, 7'd64,  8'h80, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd50,  8'h33, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd1,   8'h44, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd127, 8'h55, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd100, 8'h66, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd64,  8'h01, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd63,  8'hFE, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd2,   8'h7F, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd99,  8'h80, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd50,  8'h99, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd1,   8'hAA, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd7,   8'hBB, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd127, 8'hCC, 1'b0, NO_FIXED},
    '{OP_ENQUEUE, 7'd3,   8'h77, 1'b1,
      '{1'b0, 1'b1, 1'b0, 5'd16, ERR_FULL, 8'd0, 7'd0}},
    '{OP_DEQUEUE, 7'd5,   8'h3C, 1'b0, NO_FIXED}
  };

  sorted_priority_queue_core #(
    .DEPTH (DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one operation to the predicted queue and returns its result word.
  function automatic qresult_t queue_step(logic op, logic [PRIO_W-1:0] prio,
                                          logic [CHAR_W-1:0] ch);
    qresult_t r;
    int       pos;
    r = '0;
    if (op == OP_ENQUEUE) begin
      if (held >= DEPTH) begin
        r.err = ERR_FULL;
      end else begin
        // Entries of strictly lower urgency move one slot toward the tail.
        pos = held;
        while (pos > 0 && slot_prio[pos-1] > prio) begin
          slot_prio[pos] = slot_prio[pos-1];
          slot_char[pos] = slot_char[pos-1];
          pos--;
        end
        slot_prio[pos] = prio;
        slot_char[pos] = ch;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.err = ERR_EMPTY;
      end else begin
        r.valid = 1'b1;
        r.prio  = slot_prio[0];
        r.ch    = slot_char[0];
        for (int i = 1; i < held; i++) begin
          slot_prio[i-1] = slot_prio[i];
          slot_char[i-1] = slot_char[i];
        end
        held--;
      end
    end
    r.count = COUNT_W'(held);
    r.empty = (held == 0);
    r.full  = (held >= DEPTH);
    return r;
  endfunction

  // Input side: every accepted word updates the predictor and queues its result.
  always @(posedge clk) begin
    qresult_t predicted;
    if (rst_n && in_tvalid && in_tready) begin
      predicted = queue_step(in_tuser, in_tdata[6:0], in_tdata[14:7]);
      pending_results.push_back(word_typed ? word_fixed : predicted);
      words_in++;
    end
  end

  // Output side: every accepted result word is checked against the oldest one.
  always @(posedge clk) begin
    qresult_t got;
    qresult_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (pending_results.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= SHOW_MAX)
          $display("%0t: result word with nothing outstanding: %h", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fault_cnt++;
          if (fault_cnt <= SHOW_MAX) begin
            $display("%0t: mismatch (valid prio char err count empty full)", $realtime);
            $display("  expected %0d %0d %02h %0d %0d %0d %0d", want.valid, want.prio,
                     want.ch, want.err, want.count, want.empty, want.full);
            $display("  got      %0d %0d %02h %0d %0d %0d %0d", got.valid, got.prio,
                     got.ch, got.err, got.count, got.empty, got.full);
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once enough words are in.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && words_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one word from a falling edge and returns at the falling edge after
  // it has been taken.
  task automatic drive_word(logic op, logic [PRIO_W-1:0] prio, logic [CHAR_W-1:0] ch,
                            logic typed, qresult_t fixed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= op;
    in_tdata   <= {1'b0, ch, prio};
    word_typed = typed;
    word_fixed = fixed;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Stops offering and waits at rising edges until every result has come.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed table, then three random phases with different idling.
  initial begin
    int               enq_pct;
    int               pick;
    logic             op;
    logic [PRIO_W-1:0] prio;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      drive_word(dir_rows[i].op, dir_rows[i].prio, dir_rows[i].ch,
                 dir_rows[i].typed, dir_rows[i].fixed);

    enq_pct = 50;
    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 29 : 0;
      @(negedge clk);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Runs of enqueue-heavy and dequeue-heavy traffic sweep full and empty.
        if (n % 32 == 0) begin
          pick    = $urandom_range(2);
          enq_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
        end
        op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
        // Mostly a narrow band so that ties are common; now and then raw values.
        pick = $urandom_range(9);
        if (pick < 5)
          prio = PRIO_W'($urandom_range(6, 1));
        else if (pick < 9)
          prio = PRIO_W'($urandom_range(100, 1));
        else
          prio = PRIO_W'($urandom_range(127));
        drive_word(op, prio, CHAR_W'($urandom_range(255)), 1'b0, NO_FIXED);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fault_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_core.sv
tb/sv/tb_sorted_priority_queue_core.sv
